@@ hdl/ultrasonic_echo_ranger_assert.svh @@
// Assertion macros shared by the ultrasonic ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ranger assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ranger assertion failed");
`else
`define UER_ASSERT_IMP(label, ante, cons)
`define UER_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ hdl/uer_pkg.sv @@
// Constants and codes for the single-pin ultrasonic ranger.
`default_nettype none

package uer_pkg;

  // Measurement phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_TRIG    = 2'd1;
  localparam logic [1:0] PH_RISE    = 2'd2;
  localparam logic [1:0] PH_MEASURE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSTART = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICKS_PER_US    = 2'd0;
  localparam logic [1:0] REG_TRIGGER_US      = 2'd1;
  localparam logic [1:0] REG_RISE_TIMEOUT_US = 2'd2;
  localparam logic [1:0] REG_FALL_TIMEOUT_US = 2'd3;

  // Distance = echo_us * 1.715, done as (echo_us * 28099) >> 14.
  localparam logic [14:0] DIST_MUL   = 15'd28099;
  localparam int          DIST_SHIFT = 14;

  localparam int US_W   = 16;
  localparam int DIST_W = 17;
  localparam int PROD_W = 31;

endpackage

`default_nettype wire

@@ hdl/ultrasonic_echo_ranger.sv @@
// Top level of the single-pin ultrasonic ranger: sequencer, timers and result register.
`default_nettype none
`include "ultrasonic_echo_ranger_assert.svh"

// Each input word is one sampled clock tick of the shared sensor pin plus a start
// request, and it yields exactly one output word. A word is taken every cycle: the
// phase sequencer, microsecond prescaler and timeout compares sit between the state
// registers and a one-deep output register, and in_ready stays high unless that
// register holds a word the consumer has not taken. The output word is registered.
// The longest path is the finishing width selection followed by one
// 16 x 15 bit multiply for the distance, which lands directly in the output register.
// A start drives the pin for trigger_us microseconds, then the block waits for the
// echo to rise and times its high width; status, echo_us and distance_centi_cm hold
// the last finished measurement. Configuration writes take effect at once.
module ultrasonic_echo_ranger (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        start_req,
  input  wire logic        echo_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pin_drive,
  output logic             pin_high,
  output logic             busy_res,
  output logic             done_res,
  output logic [1:0]       status,
  output logic [15:0]      echo_us,
  output logic [16:0]      distance_centi_cm
);

  // Configuration registers.
  logic [7:0]  ticks_per_us;
  logic [7:0]  trigger_us;
  logic [15:0] rise_timeout_us;
  logic [15:0] fall_timeout_us;

  // Sequencer state.
  logic [1:0]  phase, phase_next;
  logic [7:0]  tick_prescale, tick_prescale_next;
  logic [15:0] us_count, us_count_next;

  logic        in_accept;
  logic [1:0]  ph_cur;
  logic [7:0]  tp_cur;
  logic [15:0] uc_cur;
  logic [8:0]  tp_inc;
  logic [15:0] uc_inc;
  logic        us_tick;
  logic [7:0]  tpu_eff, trig_eff;
  logic [15:0] rise_eff, fall_eff;
  logic        fin;
  logic [1:0]  fin_status;
  logic [15:0] fin_width;
  logic [uer_pkg::PROD_W-1:0] prod;
  logic [16:0] fin_dist;
  logic        counters_clear;
  logic        start_taken;
  logic        left_idle;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign pin_high  = pin_drive;

  // A limit of zero behaves as one.
  assign tpu_eff  = (ticks_per_us == '0) ? 8'd1 : ticks_per_us;
  assign trig_eff = (trigger_us == '0) ? 8'd1 : trigger_us;
  assign rise_eff = (rise_timeout_us == '0) ? 16'd1 : rise_timeout_us;
  assign fall_eff = (fall_timeout_us == '0) ? 16'd1 : fall_timeout_us;

  always_comb begin
    ph_cur = phase;
    tp_cur = tick_prescale;
    uc_cur = us_count;
    if (phase == uer_pkg::PH_IDLE && start_req) begin
      ph_cur = uer_pkg::PH_TRIG;
      tp_cur = '0;
      uc_cur = '0;
    end

    tp_inc  = {1'b0, tp_cur} + 9'd1;
    us_tick = (tp_inc >= {1'b0, tpu_eff});
    uc_inc  = uc_cur + 16'd1;

    phase_next         = ph_cur;
    tick_prescale_next = us_tick ? 8'd0 : tp_inc[7:0];
    us_count_next      = us_tick ? uc_inc : uc_cur;
    fin        = 1'b0;
    fin_status = uer_pkg::ST_OK;
    fin_width  = '0;

    unique case (ph_cur)
      uer_pkg::PH_IDLE: begin
        tick_prescale_next = tp_cur;
        us_count_next      = uc_cur;
      end
      uer_pkg::PH_TRIG: begin
        if (us_tick && uc_inc >= {8'd0, trig_eff}) begin
          phase_next         = uer_pkg::PH_RISE;
          tick_prescale_next = '0;
          us_count_next      = '0;
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          phase_next         = uer_pkg::PH_MEASURE;
          tick_prescale_next = '0;
          us_count_next      = '0;
        end else if (us_tick && uc_inc >= rise_eff) begin
          fin        = 1'b1;
          fin_status = uer_pkg::ST_NOSTART;
        end
      end
      uer_pkg::PH_MEASURE: begin
        if (!echo_level) begin
          fin = 1'b1;
          if (uc_cur == '0) begin
            fin_status = uer_pkg::ST_EMPTY;
          end else begin
            fin_width = uc_cur;
          end
        end else if (us_tick && uc_inc >= fall_eff) begin
          fin        = 1'b1;
          fin_status = uer_pkg::ST_TOOLONG;
          fin_width  = uc_inc;
        end
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
      end
    endcase

    if (fin) begin
      phase_next         = uer_pkg::PH_IDLE;
      tick_prescale_next = '0;
      us_count_next      = '0;
    end
  end

  // Fixed-point scaling of the width to hundredths of a centimeter.
  assign prod     = uer_pkg::PROD_W'(fin_width) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);
  assign fin_dist = (fin_status == uer_pkg::ST_OK) ?
                    prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W] : 17'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us      <= 8'd16;
      trigger_us        <= 8'd10;
      rise_timeout_us   <= 16'd30000;
      fall_timeout_us   <= 16'd30000;
      phase             <= uer_pkg::PH_IDLE;
      tick_prescale     <= '0;
      us_count          <= '0;
      out_valid         <= 1'b0;
      pin_drive         <= 1'b0;
      busy_res          <= 1'b0;
      done_res          <= 1'b0;
      status            <= uer_pkg::ST_OK;
      echo_us           <= '0;
      distance_centi_cm <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          uer_pkg::REG_TICKS_PER_US:    ticks_per_us    <= cfg_data[7:0];
          uer_pkg::REG_TRIGGER_US:      trigger_us      <= cfg_data[7:0];
          uer_pkg::REG_RISE_TIMEOUT_US: rise_timeout_us <= cfg_data;
          uer_pkg::REG_FALL_TIMEOUT_US: fall_timeout_us <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        phase         <= phase_next;
        tick_prescale <= tick_prescale_next;
        us_count      <= us_count_next;
        out_valid     <= 1'b1;
        pin_drive     <= (ph_cur == uer_pkg::PH_TRIG);
        busy_res      <= (ph_cur != uer_pkg::PH_IDLE);
        done_res      <= fin;
        // The result fields double as the record of the last finished measurement.
        if (fin) begin
          status            <= fin_status;
          echo_us           <= fin_width;
          distance_centi_cm <= fin_dist;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign counters_clear = (tick_prescale == '0) && (us_count == '0);
  assign start_taken    = in_accept && phase == uer_pkg::PH_IDLE && start_req;
  assign left_idle      = (phase == uer_pkg::PH_TRIG) || (phase == uer_pkg::PH_RISE);

  `UER_ASSERT_IMP(a_idle_counters_clear, phase == uer_pkg::PH_IDLE, counters_clear)
  `UER_ASSERT_IMP(a_dist_only_when_ok, status != uer_pkg::ST_OK, distance_centi_cm == '0)
  `UER_ASSERT_IMP(a_done_while_busy, out_valid && done_res, busy_res)
  `UER_ASSERT_NXT(a_start_leaves_idle, start_taken, left_idle)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the single-pin ultrasonic ranger: directed table, random runs, then register extremes.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam logic [31:0] DIST_SCALE_Q14 = 32'd28099;

  typedef struct packed {
    logic        drive;
    logic        high;
    logic        busy;
    logic        done;
    logic [1:0]  st;
    logic [15:0] us;
    logic [16:0] dcm;
  } ranger_word_t;

  typedef struct packed {
    bit           is_cfg;
    logic [1:0]   idx;
    logic [15:0]  data;
    bit           start;
    bit           echo;
    bit           typed;
    ranger_word_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_req = 1'b0;
  logic echo_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pin_drive;
  logic pin_high;
  logic busy_res;
  logic done_res;
  logic [1:0] status;
  logic [15:0] echo_us;
  logic [16:0] distance_centi_cm;

  bit idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned n_fail = 0;
  ranger_word_t pending_readings[$];

  // Predictor copy of the registers and of the sequencer state.
  logic [7:0]  cfg_tpu = 8'd16;
  logic [7:0]  cfg_trig = 8'd10;
  logic [15:0] cfg_rise = 16'd30000;
  logic [15:0] cfg_fall = 16'd30000;
  logic [1:0]  ph = uer_pkg::PH_IDLE;
  logic [7:0]  presc = '0;
  logic [15:0] us_cnt = '0;
  logic [1:0]  rd_st = uer_pkg::ST_OK;
  logic [15:0] rd_us = '0;
  logic [16:0] rd_dist = '0;

  ultrasonic_echo_ranger i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_req         (start_req),
    .echo_level        (echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pin_drive         (pin_drive),
    .pin_high          (pin_high),
    .busy_res          (busy_res),
    .done_res          (done_res),
    .status            (status),
    .echo_us           (echo_us),
    .distance_centi_cm (distance_centi_cm)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A register that reads zero behaves as one.
  function automatic int unsigned floor1(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic bit us_done();
    int unsigned nxt;
    nxt = presc + 1;
    if (nxt >= floor1(cfg_tpu)) begin
      presc = '0;
      return 1'b1;
    end
    presc = nxt[7:0];
    return 1'b0;
  endfunction

  function automatic void go(input logic [1:0] p);
    ph = p;
    presc = '0;
    us_cnt = '0;
  endfunction

  function automatic void close_out(input logic [1:0] st, input logic [15:0] width);
    logic [31:0] prod;
    prod = {16'd0, width} * DIST_SCALE_Q14;
    rd_st = st;
    rd_us = width;
    rd_dist = (st == uer_pkg::ST_OK) ? prod[30:14] : '0;
    go(uer_pkg::PH_IDLE);
  endfunction

  // One clock tick of the ranger: returns the output word that this input word causes.
  function automatic ranger_word_t ranger_step(input bit s, input bit e);
    ranger_word_t w;
    w = '0;
    if (ph == uer_pkg::PH_IDLE && s)
      go(uer_pkg::PH_TRIG);
    w.drive = (ph == uer_pkg::PH_TRIG);
    w.high = w.drive;
    w.busy = (ph != uer_pkg::PH_IDLE);
    case (ph)
      uer_pkg::PH_TRIG: begin
        if (us_done()) begin
          us_cnt = us_cnt + 1'b1;
          if (us_cnt >= floor1(cfg_trig))
            go(uer_pkg::PH_RISE);
        end
      end
      uer_pkg::PH_RISE: begin
        if (e) begin
          go(uer_pkg::PH_MEASURE);
        end else if (us_done()) begin
          us_cnt = us_cnt + 1'b1;
          if (us_cnt >= floor1(cfg_rise)) begin
            close_out(uer_pkg::ST_NOSTART, '0);
            w.done = 1'b1;
          end
        end
      end
      uer_pkg::PH_MEASURE: begin
        if (!e) begin
          close_out((us_cnt == 0) ? uer_pkg::ST_EMPTY : uer_pkg::ST_OK, us_cnt);
          w.done = 1'b1;
        end else if (us_done()) begin
          us_cnt = us_cnt + 1'b1;
          if (us_cnt >= floor1(cfg_fall)) begin
            close_out(uer_pkg::ST_TOOLONG, us_cnt);
            w.done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    w.st = rd_st;
    w.us = rd_us;
    w.dcm = rd_dist;
    return w;
  endfunction

  function automatic plan_row_t tick_row(input bit s, input bit e);
    plan_row_t r;
    r = '0;
    r.start = s;
    r.echo = e;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t seen_row(input bit s, input bit e, input bit drive,
                                         input bit busy, input bit done,
                                         input logic [1:0] st, input logic [15:0] us,
                                         input logic [16:0] dcm);
    plan_row_t r;
    r = tick_row(s, e);
    r.typed = 1'b1;
    r.want = '{drive: drive, high: drive, busy: busy, done: done, st: st, us: us,
               dcm: dcm};
    return r;
  endfunction

  // Hands one input word to the block; the prediction is queued once it is taken.
  task automatic send_tick(input bit s, input bit e, input bit has_want,
                           input ranger_word_t want);
    ranger_word_t pred;
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    echo_level <= e;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    pred = ranger_step(s, e);
    pending_readings.push_back(has_want ? want : pred);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      uer_pkg::REG_TICKS_PER_US:    cfg_tpu = val[7:0];
      uer_pkg::REG_TRIGGER_US:      cfg_trig = val[7:0];
      uer_pkg::REG_RISE_TIMEOUT_US: cfg_rise = val;
      uer_pkg::REG_FALL_TIMEOUT_US: cfg_fall = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Plays the sensor for one measurement: the echo rises rise_wait ticks after the
  // trigger and stays high for high_len ticks. Any measurement still running is
  // first finished with random pin noise.
  task automatic run_measurement(input int unsigned rise_wait, input int unsigned high_len);
    int unsigned d;
    int unsigned w;
    d = rise_wait;
    w = high_len;
    while (ph != uer_pkg::PH_IDLE)
      send_tick(coin(), coin(), 1'b0, '0);
    send_tick(1'b1, coin(), 1'b0, '0);
    while (ph != uer_pkg::PH_IDLE) begin
      case (ph)
        uer_pkg::PH_RISE: begin
          send_tick(coin(), d == 0, 1'b0, '0);
          if (d != 0) d--;
        end
        uer_pkg::PH_MEASURE: begin
          send_tick(coin(), w != 0, 1'b0, '0);
          if (w != 0) w--;
        end
        default: send_tick(coin(), coin(), 1'b0, '0);
      endcase
    end
  endtask

  always @(posedge clk) out_ready <= !idle_on || ($urandom_range(99) >= 27);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : check_readings
    ranger_word_t want;
    ranger_word_t got;
    if (!rst && out_valid && out_ready) begin
      got = {pin_drive, pin_high, busy_res, done_res, status, echo_us, distance_centi_cm};
      if (pending_readings.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("cycle %0d: output word with none expected", cycle_count);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("cycle %0d: expected drive=%b high=%b busy=%b done=%b st=%0d us=%0d dcm=%0d",
                     cycle_count, want.drive, want.high, want.busy, want.done, want.st,
                     want.us, want.dcm);
            $display("cycle %0d:      got drive=%b high=%b busy=%b done=%b st=%0d us=%0d dcm=%0d",
                     cycle_count, got.drive, got.high, got.busy, got.done, got.st,
                     got.us, got.dcm);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    int unsigned seg_start;
    int unsigned roll;
    int unsigned lim;
    int unsigned d;
    int unsigned w;
    logic [15:0] v_tpu;
    logic [15:0] v_trig;
    logic [15:0] v_rise;
    logic [15:0] v_fall;

    // Reset values show first, then the pulse is cut short by lowering the trigger
    // length below the count already reached, and a zero prescaler acts as one.
    plan.push_back(seen_row(0, 0, 0, 0, 0, uer_pkg::ST_OK, 0, 0));
    plan.push_back(seen_row(1, 1, 1, 1, 0, uer_pkg::ST_OK, 0, 0));
    plan.push_back(cfg_row(uer_pkg::REG_TICKS_PER_US, 16'd1));
    plan.push_back(tick_row(0, 0));
    plan.push_back(tick_row(0, 1));
    plan.push_back(cfg_row(uer_pkg::REG_TRIGGER_US, 16'd1));
    plan.push_back(tick_row(0, 0));
    plan.push_back(cfg_row(uer_pkg::REG_TICKS_PER_US, 16'd0));
    plan.push_back(cfg_row(uer_pkg::REG_RISE_TIMEOUT_US, 16'd2));
    plan.push_back(cfg_row(uer_pkg::REG_FALL_TIMEOUT_US, 16'd3));
    // No echo arrives; the start in the middle is ignored.
    plan.push_back(tick_row(1, 0));
    plan.push_back(seen_row(0, 0, 0, 1, 1, uer_pkg::ST_NOSTART, 0, 0));
    // Echo falls before a whole microsecond.
    plan.push_back(tick_row(1, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(seen_row(0, 0, 0, 1, 1, uer_pkg::ST_EMPTY, 0, 0));
    // Good two microsecond echo.
    plan.push_back(tick_row(1, 0));
    plan.push_back(tick_row(0, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(seen_row(0, 0, 0, 1, 1, uer_pkg::ST_OK, 2, 3));
    // Echo held past the fall timeout.
    plan.push_back(tick_row(1, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(tick_row(0, 1));
    plan.push_back(seen_row(0, 1, 0, 1, 1, uer_pkg::ST_TOOLONG, 3, 0));
    plan.push_back(tick_row(0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].start, plan[i].echo, plan[i].typed, plan[i].want);
      end
    end

    // Random segments, each with fresh register values. One runs without idling.
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      idle_on = (seg != 4);
      roll = $urandom_range(99);
      v_tpu = (roll < 80) ? 16'($urandom_range(1, 3)) : (roll < 90) ? 16'd0 : 16'd255;
      roll = $urandom_range(99);
      v_trig = (roll < 80) ? 16'($urandom_range(1, 4)) : (roll < 90) ? 16'd0 : 16'd255;
      if (v_tpu == 16'd255)
        v_trig = 16'd1;
      roll = $urandom_range(99);
      v_rise = (roll < 70) ? 16'($urandom_range(1, 12)) : (roll < 80) ? 16'd0 :
               (roll < 90) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
      roll = $urandom_range(99);
      v_fall = (roll < 70) ? 16'($urandom_range(1, 12)) : (roll < 80) ? 16'd0 :
               (roll < 90) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
      // The upper byte of an 8-bit register write must be dropped.
      write_reg(uer_pkg::REG_TICKS_PER_US, {8'($urandom_range(255)), v_tpu[7:0]});
      write_reg(uer_pkg::REG_TRIGGER_US, {8'($urandom_range(255)), v_trig[7:0]});
      write_reg(uer_pkg::REG_RISE_TIMEOUT_US, v_rise);
      write_reg(uer_pkg::REG_FALL_TIMEOUT_US, v_fall);
      seg_start = words_sent;
      while (words_sent - seg_start < 150) begin
        if (ph != uer_pkg::PH_IDLE) begin
          send_tick(coin(), coin(), 1'b0, '0);
        end else if ($urandom_range(99) < 25) begin
          repeat ($urandom_range(1, 6))
            send_tick(coin(), coin(), 1'b0, '0);
        end else begin
          repeat ($urandom_range(3))
            send_tick(1'b0, coin(), 1'b0, '0);
          lim = floor1(cfg_rise) * floor1(cfg_tpu) + 2;
          if (lim > 80) lim = 80;
          d = $urandom_range(lim);
          lim = floor1(cfg_fall) * floor1(cfg_tpu) + 2;
          if (lim > 80) lim = 80;
          w = ($urandom_range(9) == 0) ? $urandom_range(floor1(cfg_tpu) - 1) :
                                          $urandom_range(lim);
          run_measurement(d, w);
        end
      end
    end

    // Register extremes: longest pulse and widest timeouts, then the slowest prescaler.
    settle();
    idle_on = 1'b0;
    write_reg(uer_pkg::REG_TICKS_PER_US, 16'd1);
    write_reg(uer_pkg::REG_TRIGGER_US, 16'd255);
    write_reg(uer_pkg::REG_RISE_TIMEOUT_US, 16'hFFFF);
    write_reg(uer_pkg::REG_FALL_TIMEOUT_US, 16'hFFFF);
    run_measurement(3, 40);
    settle();
    write_reg(uer_pkg::REG_TICKS_PER_US, 16'd255);
    write_reg(uer_pkg::REG_TRIGGER_US, 16'd1);
    write_reg(uer_pkg::REG_RISE_TIMEOUT_US, 16'd1);
    write_reg(uer_pkg::REG_FALL_TIMEOUT_US, 16'd1);
    run_measurement(600, 0);

    settle();
    repeat (4) @(posedge clk);
    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
